// ----- sv/isz_pkg.sv -----
// Shared types and constants for the image header size sniffer.
package isz_pkg;

    localparam int HDR_LEN = 26;
    localparam int HDR_IDX_W = $clog2(HDR_LEN);

    // JPEG marker codes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOS = 8'hDA;
    localparam logic [7:0] MK_SOF_LO = 8'hC0;
    localparam logic [7:0] MK_SOF_HI = 8'hC3;
    localparam logic [7:0] MK_SOI = 8'hD8;

    // Signatures, first byte in the most significant position
    localparam logic [47:0] SIG_GIF87 = "GIF87a";
    localparam logic [47:0] SIG_GIF89 = "GIF89a";
    localparam logic [63:0] SIG_PNG = 64'h89504E470D0A1A0A;
    localparam logic [31:0] SIG_IHDR = "IHDR";
    localparam logic [15:0] SIG_BM = "BM";

    localparam logic [31:0] BMP_CORE_HDR = 32'd12;
    localparam logic [31:0] BMP_INFO_HDR = 32'd40;

    typedef enum logic [2:0] {
        FMT_SHORT = 3'd0,
        FMT_GIF = 3'd1,
        FMT_PNG = 3'd2,
        FMT_OLD_PNG = 3'd3,
        FMT_JPEG = 3'd4,
        FMT_BMP = 3'd5,
        FMT_ICO = 3'd6,
        FMT_OTHER = 3'd7
    } t_fmt;

    // header bytes, entry 0 is the first byte of the file
    typedef logic [HDR_LEN-1:0][7:0] t_hdr;

    typedef struct packed {
        logic seen;
        logic [15:0] width;
        logic [15:0] height;
    } t_frame;

    typedef struct packed {
        t_fmt fmt;
        logic known;
        logic [31:0] width;
        logic [31:0] height;
    } t_dec;

endpackage

// ----- sv/isz_if.sv -----
// Word channels: input bytes and parse results.
interface isz_in_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface isz_out_if;
    logic valid;
    logic ready;
    logic found;
    logic [2:0] image_format;
    logic size_known;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [31:0] byte_total;

    modport source(output valid, output found, output image_format, output size_known,
                   output image_width, output image_height, output byte_total,
                   input ready);
    modport sink(input valid, input found, input image_format, input size_known,
                 input image_width, input image_height, input byte_total,
                 output ready);
endinterface

// ----- sv/isz_walk.sv -----
// JPEG marker walk: tracks segments and captures the SOF frame size.
module isz_walk import isz_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    output t_frame     o_frame_next
);

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_SOF,
        PH_DONE
    } t_phase;

    // length field, precision byte plus two BE16 fields
    localparam logic [15:0] SOF_SKIP = 16'd7;

    t_phase r_phase, n_phase;
    logic [15:0] r_skip, n_skip;
    logic [23:0] r_shift, n_shift;
    logic [15:0] r_fw, n_fw;
    logic [15:0] r_fh, n_fh;
    logic r_seen, n_seen;
    logic [31:0] shifted;
    logic [15:0] seg_len;

    assign shifted = {r_shift, i_byte};
    assign seg_len = {r_shift[7:0], i_byte};

    always_comb begin
        n_phase = r_phase;
        n_skip = r_skip;
        n_shift = r_shift;
        n_fw = r_fw;
        n_fh = r_fh;
        n_seen = r_seen;
        if (i_step) begin
            case (r_phase)
                PH_SEARCH: begin
                    if (i_byte == MK_PREFIX) n_phase = PH_MARKER;
                end
                PH_MARKER: begin
                    if (i_byte == MK_PREFIX) begin
                        n_phase = PH_MARKER;
                    end else if (i_byte == MK_SOS) begin
                        n_phase = PH_DONE;
                    end else if (i_byte inside {[MK_SOF_LO:MK_SOF_HI]}) begin
                        n_skip = SOF_SKIP;
                        n_phase = PH_SOF;
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_shift = {16'd0, i_byte};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_skip = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                    n_phase = (n_skip != 16'd0) ? PH_SKIP : PH_SEARCH;
                end
                PH_SKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) n_phase = PH_SEARCH;
                end
                PH_SOF: begin
                    n_shift = shifted[23:0];
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) begin
                        n_fh = shifted[31:16];
                        n_fw = shifted[15:0];
                        n_seen = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    assign o_frame_next = '{seen: n_seen, width: n_fw, height: n_fh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_SEARCH;
            r_skip <= '0;
            r_shift <= '0;
            r_fw <= '0;
            r_fh <= '0;
            r_seen <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_skip <= n_skip;
            r_shift <= n_shift;
            r_fw <= n_fw;
            r_fh <= n_fh;
            r_seen <= n_seen;
        end
    end

endmodule

// ----- sv/isz_decode.sv -----
// Format detection and size extraction from the header bytes.
module isz_decode import isz_pkg::*; (
    input  t_hdr   i_hdr,
    input  logic   i_found,
    input  t_frame i_frame,
    output t_dec   o_dec
);

    logic [15:0] le16_0, le16_2, le16_4, le16_6, le16_8, le16_18, le16_20;
    logic [31:0] le32_14, le32_18, le32_22;
    logic [31:0] be32_8, be32_12, be32_16, be32_20;
    logic [31:0] bmp_h;
    logic is_gif, is_sig, is_ihdr;

    assign le16_0 = {i_hdr[1], i_hdr[0]};
    assign le16_2 = {i_hdr[3], i_hdr[2]};
    assign le16_4 = {i_hdr[5], i_hdr[4]};
    assign le16_6 = {i_hdr[7], i_hdr[6]};
    assign le16_8 = {i_hdr[9], i_hdr[8]};
    assign le16_18 = {i_hdr[19], i_hdr[18]};
    assign le16_20 = {i_hdr[21], i_hdr[20]};
    assign le32_14 = {i_hdr[17], i_hdr[16], i_hdr[15], i_hdr[14]};
    assign le32_18 = {i_hdr[21], i_hdr[20], i_hdr[19], i_hdr[18]};
    assign le32_22 = {i_hdr[25], i_hdr[24], i_hdr[23], i_hdr[22]};
    assign be32_8 = {i_hdr[8], i_hdr[9], i_hdr[10], i_hdr[11]};
    assign be32_12 = {i_hdr[12], i_hdr[13], i_hdr[14], i_hdr[15]};
    assign be32_16 = {i_hdr[16], i_hdr[17], i_hdr[18], i_hdr[19]};
    assign be32_20 = {i_hdr[20], i_hdr[21], i_hdr[22], i_hdr[23]};

    assign is_gif = ({i_hdr[0], i_hdr[1], i_hdr[2], i_hdr[3], i_hdr[4], i_hdr[5]} == SIG_GIF87)
                 || ({i_hdr[0], i_hdr[1], i_hdr[2], i_hdr[3], i_hdr[4], i_hdr[5]} == SIG_GIF89);
    assign is_sig = {i_hdr[0], i_hdr[1], i_hdr[2], i_hdr[3],
                     i_hdr[4], i_hdr[5], i_hdr[6], i_hdr[7]} == SIG_PNG;
    assign is_ihdr = {i_hdr[12], i_hdr[13], i_hdr[14], i_hdr[15]} == SIG_IHDR;

    // magnitude of the signed height; the most negative value maps to itself
    assign bmp_h = le32_22[31] ? 32'd0 - le32_22 : le32_22;

    always_comb begin
        o_dec = '{fmt: FMT_SHORT, known: 1'b0, width: 32'd0, height: 32'd0};
        if (i_found) begin
            if (is_gif) begin
                o_dec = '{fmt: FMT_GIF, known: 1'b1, width: {16'd0, le16_6},
                          height: {16'd0, le16_8}};
            end else if (is_sig && is_ihdr) begin
                o_dec = '{fmt: FMT_PNG, known: 1'b1, width: be32_16, height: be32_20};
            end else if (is_sig) begin
                o_dec = '{fmt: FMT_OLD_PNG, known: 1'b1, width: be32_8, height: be32_12};
            end else if (i_hdr[0] == MK_PREFIX && i_hdr[1] == MK_SOI) begin
                o_dec.fmt = FMT_JPEG;
                if (i_frame.seen) begin
                    o_dec.known = 1'b1;
                    o_dec.width = {16'd0, i_frame.width};
                    o_dec.height = {16'd0, i_frame.height};
                end
            end else if ({i_hdr[0], i_hdr[1]} == SIG_BM) begin
                o_dec.fmt = FMT_BMP;
                if (le32_14 == BMP_CORE_HDR) begin
                    o_dec.known = 1'b1;
                    o_dec.width = {16'd0, le16_18};
                    o_dec.height = {16'd0, le16_20};
                end else if (le32_14 >= BMP_INFO_HDR) begin
                    o_dec.known = 1'b1;
                    o_dec.width = le32_18;
                    o_dec.height = bmp_h;
                end
            end else if (le16_0 == 16'd0 && le16_2 == 16'd1) begin
                o_dec.fmt = FMT_ICO;
                if (le16_4 <= 16'd1) begin
                    o_dec.known = 1'b1;
                    o_dec.width = {24'd0, i_hdr[6]};
                    o_dec.height = {24'd0, i_hdr[7]};
                end
            end else begin
                o_dec.fmt = FMT_OTHER;
            end
        end
    end

endmodule

// ----- sv/image_header_size_sniffer_core.sv -----
// A result becomes valid once the word carrying the last byte has been taken and
// the input register has passed it to the result register.
// Throughput: one byte per cycle; the input register and the result register each
// take a new word while the stage behind them drains, so only a result held by a
// stalled sink blocks a following last byte.
// Reset (synchronous, active low) clears the byte count, the marker walk and both
// stage valids; the header store is not cleared, every byte of it is written first.
module image_header_size_sniffer_core import isz_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    isz_in_if.sink i_in,
    isz_out_if.source o_out
);

    logic r_in_valid;
    logic [7:0] r_in_byte;
    logic r_in_last;

    logic [COUNT_BITS-1:0] r_count, n_count;
    t_hdr r_hdr, n_hdr;
    logic [63:0] count_ext;

    logic r_out_valid;
    logic r_out_found;
    t_fmt r_out_fmt;
    logic r_out_known;
    logic [31:0] r_out_w, r_out_h, r_out_total;

    logic out_free, process, hdr_wr, found;
    t_frame frame_next;
    t_dec dec;

    assign out_free = !r_out_valid || o_out.ready;
    // a last byte waits until the result register can take its result
    assign process = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = !r_in_valid || process;

    assign n_count = (r_count != '1) ? r_count + 1'b1 : r_count;
    assign hdr_wr = r_count < COUNT_BITS'(HDR_LEN);
    assign found = n_count >= COUNT_BITS'(HDR_LEN);
    assign count_ext = 64'(n_count);

    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            n_hdr[i] = (hdr_wr && r_count[HDR_IDX_W-1:0] == HDR_IDX_W'(i)) ? r_in_byte
                                                                            : r_hdr[i];
        end
    end

    isz_walk u_walk (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_step(process && r_count >= COUNT_BITS'(2)),
        .i_clear(process && r_in_last),
        .i_byte(r_in_byte),
        .o_frame_next(frame_next)
    );

    isz_decode u_decode (
        .i_hdr(n_hdr),
        .i_found(found),
        .i_frame(frame_next),
        .o_dec(dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (process) begin
            r_count <= r_in_last ? '0 : n_count;
        end
        if (process) r_hdr <= n_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (process && r_in_last) begin
            r_out_found <= found;
            r_out_fmt <= dec.fmt;
            r_out_known <= dec.known;
            r_out_w <= dec.width;
            r_out_h <= dec.height;
            r_out_total <= (count_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : count_ext[31:0];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.found = r_out_found;
    assign o_out.image_format = r_out_fmt;
    assign o_out.size_known = r_out_known;
    assign o_out.image_width = r_out_w;
    assign o_out.image_height = r_out_h;
    assign o_out.byte_total = r_out_total;

endmodule

// ----- sv/isz_chk.sv -----
// Port-level checks on the sniffer's result channel, bound to the top level.
module isz_chk import isz_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [2:0]  i_format,
    input logic        i_known,
    input logic [31:0] i_width,
    input logic [31:0] i_height,
    input logic [31:0] i_total
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_total)
            && $stable(i_width) && $stable(i_height) && $stable(i_format))
        else $error("result changed while stalled");

    // short file: no format, no size, and fewer header bytes than needed
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_format == FMT_SHORT && !i_known
            && i_total < 32'(HDR_LEN))
        else $error("short file result inconsistent");

    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_format != FMT_SHORT && i_total >= 32'(HDR_LEN))
        else $error("found result with short length");

    a_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_known |-> i_width == 32'd0 && i_height == 32'd0)
        else $error("size given while unknown");

endmodule

bind image_header_size_sniffer_core isz_chk u_isz_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_found(o_out.found),
    .i_format(o_out.image_format),
    .i_known(o_out.size_known),
    .i_width(o_out.image_width),
    .i_height(o_out.image_height),
    .i_total(o_out.byte_total)
);
